@@ sv/ptw4_pkg.sv @@
// Package: item types, status and page size codes, controller-datapath link types.
`default_nettype none

package ptw4_pkg;

	// Input word: one table write or one translation request
	typedef struct packed {
		logic        kind;
		logic [12:0] word_index;
		logic [63:0] entry_word;
		logic [47:0] virt_addr;
	} in_item_t;

	// Output word: one answer per accepted input word
	typedef struct packed {
		logic [1:0]  status;
		logic [51:0] phys_addr;
		logic [1:0]  pg_size;
	} out_item_t;

	// Item kinds
	localparam logic KIND_WRITE     = 1'b0;
	localparam logic KIND_TRANSLATE = 1'b1;

	// Answer status codes
	localparam logic [1:0] ST_MAPPED  = 2'd0;
	localparam logic [1:0] ST_ABSENT  = 2'd1;
	localparam logic [1:0] ST_OUTSIDE = 2'd2;
	localparam logic [1:0] ST_WRITTEN = 2'd3;

	// Page size codes
	localparam logic [1:0] SZ_4K = 2'd0;
	localparam logic [1:0] SZ_2M = 2'd1;
	localparam logic [1:0] SZ_1G = 2'd2;

	// Walk levels
	localparam logic [1:0] LVL_TOP  = 2'd0;
	localparam logic [1:0] LVL_1G   = 2'd1;
	localparam logic [1:0] LVL_2M   = 2'd2;
	localparam logic [1:0] LVL_LAST = 2'd3;

	// Answer source selects
	localparam logic [1:0] RES_WRITE    = 2'd0;
	localparam logic [1:0] RES_ROOT_OUT = 2'd1;
	localparam logic [1:0] RES_WALK     = 2'd2;

	// Commands from controller to datapath
	typedef struct packed {
		logic       clr_en;
		logic       wr_en;
		logic       rd_first;
		logic       rd_next;
		logic [1:0] level;
		logic [1:0] res_sel;
		logic       out_load;
		logic       load_va;
	} dp_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic clr_last;
		logic root_out;
		logic walk_cont;
	} dp_sts_t;

endpackage

`default_nettype wire

@@ sv/ptw4_ctrl.sv @@
// Controller: state machine sequencing clear pass, writes and table walks.
`default_nettype none

module ptw4_ctrl
	import ptw4_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	input  wire logic    in_kind,
	output logic         in_ready,
	input  wire logic    out_ready,
	output logic         out_valid,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd
);

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_RESP  = 2'd2;
	localparam logic [1:0] S_WALK  = 2'd3;

	logic [1:0] state_q, state_d;
	logic [1:0] level_q, level_d;
	logic [1:0] res_q, res_d;
	logic       out_valid_q;
	logic       accept;
	logic       out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// Decode next state and datapath commands
	always_comb begin
		state_d = state_q;
		level_d = level_q;
		res_d   = res_q;
		cmd          = '0;
		cmd.level    = level_q;
		cmd.res_sel  = res_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_en = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					cmd.load_va = 1'b1;
					if (in_kind == KIND_WRITE) begin
						cmd.wr_en = 1'b1;
						res_d     = RES_WRITE;
						state_d   = S_RESP;
					end else if (sts.root_out) begin
						res_d   = RES_ROOT_OUT;
						state_d = S_RESP;
					end else begin
						cmd.rd_first = 1'b1;
						level_d      = LVL_TOP;
						state_d      = S_WALK;
					end
				end
			end
			S_RESP: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_WALK: begin
				if (sts.walk_cont) begin
					cmd.rd_next = 1'b1;
					level_d     = level_q + 2'd1;
				end else begin
					cmd.res_sel = RES_WALK;
					if (out_free) begin
						cmd.out_load = 1'b1;
						state_d      = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	// Hold state, level and answer source
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			level_q <= LVL_TOP;
			res_q   <= RES_WRITE;
		end else begin
			state_q <= state_d;
			level_q <= level_d;
			res_q   <= res_d;
		end
	end

	// Output word valid: set on load, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

@@ sv/ptw4_dp.sv @@
// Datapath: table memory, root register, walk decode and output word register.
`default_nettype none

module ptw4_dp
	import ptw4_pkg::*;
#(
	parameter int TABLE_FRAMES = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	input  wire logic [3:0] cfg_data,
	input  wire in_item_t   in_data,
	input  wire dp_cmd_t    cmd,
	output dp_sts_t         sts,
	output out_item_t       out_data
);

	localparam int FW    = $clog2(TABLE_FRAMES);
	localparam int AW    = FW + 9;
	localparam int DEPTH = TABLE_FRAMES * 512;

	logic [63:0]    mem [DEPTH];
	logic [63:0]    rdata_q;
	logic [47:0]    va_q;
	logic [3:0]     root_q;
	logic [AW-1:0]  clr_cnt_q;
	logic [AW-1:0]  wr_addr;
	logic [63:0]    wr_data;
	logic           wr_en;
	logic           in_range;
	logic [AW-1:0]  rd_addr;
	logic           rd_en;
	logic [1:0]     next_level;
	logic [8:0]     next_idx;
	logic           next_out;
	out_item_t      res;
	out_item_t      out_q;

	// Root frame register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q <= 4'd0;
		end else if (cfg_valid) begin
			root_q <= cfg_data;
		end
	end

	// Clear pass address counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_en) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
		end
	end

	// Write port: clear pass or table entry write
	assign in_range = {19'd0, in_data.word_index} < 32'(DEPTH);
	assign wr_en    = cmd.clr_en || (cmd.wr_en && in_range);
	assign wr_addr  = cmd.clr_en ? clr_cnt_q : AW'(in_data.word_index);
	assign wr_data  = cmd.clr_en ? 64'd0 : in_data.entry_word;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Pick index of the level being read next
	assign next_level = cmd.level + 2'd1;
	always_comb begin
		case (next_level)
			LVL_1G:   next_idx = va_q[38:30];
			LVL_2M:   next_idx = va_q[29:21];
			LVL_LAST: next_idx = va_q[20:12];
			default:  next_idx = va_q[47:39];
		endcase
	end

	// Read port: root table or frame from the last entry
	assign rd_en   = cmd.rd_first || cmd.rd_next;
	assign rd_addr = cmd.rd_first ? {FW'(root_q), in_data.virt_addr[47:39]}
	                              : {rdata_q[12 +: FW], next_idx};

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// Capture the virtual address of an accepted word
	always_ff @(posedge clk) begin
		if (cmd.load_va) begin
			va_q <= in_data.virt_addr;
		end
	end

	// Walk decode on the entry just read
	assign next_out = rdata_q[51:12] >= 40'(TABLE_FRAMES);

	assign sts.clr_last  = (clr_cnt_q == AW'(DEPTH - 1));
	assign sts.root_out  = 32'(root_q) >= 32'(TABLE_FRAMES);
	assign sts.walk_cont = rdata_q[0] && (cmd.level != LVL_LAST) && !rdata_q[7] && !next_out;

	// Form the answer
	always_comb begin
		res = '0;
		case (cmd.res_sel)
			RES_WRITE: begin
				res.status = ST_WRITTEN;
			end
			RES_ROOT_OUT: begin
				res.status = ST_OUTSIDE;
			end
			RES_WALK: begin
				if (!rdata_q[0]) begin
					res.status = ST_ABSENT;
				end else if (cmd.level == LVL_LAST) begin
					res.status    = ST_MAPPED;
					res.phys_addr = {rdata_q[51:12], va_q[11:0]};
					res.pg_size   = SZ_4K;
				end else if (rdata_q[7]) begin
					res.status = ST_MAPPED;
					if (cmd.level == LVL_1G) begin
						res.phys_addr = {rdata_q[51:30], va_q[29:0]};
						res.pg_size   = SZ_1G;
					end else begin
						res.phys_addr = {rdata_q[51:21], va_q[20:0]};
						res.pg_size   = SZ_2M;
					end
				end else begin
					res.status = ST_OUTSIDE;
				end
			end
			default: begin
				res.status = ST_ABSENT;
			end
		endcase
	end

	// Output word register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q <= res;
		end
	end

	assign out_data = out_q;

endmodule

`default_nettype wire

@@ sv/page_table_walker_4level.sv @@
// Top level: four-level page table walker with its own table store.
//
// Channels: in_valid/in_ready carry one in_item_t word, either a table entry
// write (kind 0) or a translation (kind 1). out_valid/out_ready return one
// out_item_t word for every accepted input word, in order. cfg_valid/cfg_ready
// write the 4-bit root frame; cfg_ready is always high, write only while idle.
// Timing: a write answers through the S_RESP state and the output register.
// A translation reads one table entry per cycle from the single-port-read
// table memory, then loads its answer into the output register; the next
// word can be taken once that answer is loaded, and walks that stop early
// read fewer entries. Words are taken one at a time.
// Reset: root frame returns to 0 and the table memory is cleared to
// non-present, one entry per cycle, over all TABLE_FRAMES * 512 entries, with
// in_ready low throughout; configuration writes are taken during the clear.
// Stall: a finished answer waits in the output register while out_ready is
// low; a further input word is still accepted and its walk runs up to the
// point of answering, then holds until the output register frees.
`default_nettype none

module page_table_walker_4level
	import ptw4_pkg::*;
#(
	parameter int TABLE_FRAMES = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [3:0] cfg_data,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire in_item_t   in_data,
	output logic            out_valid,
	input  wire logic       out_ready,
	output out_item_t       out_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg_ready = 1'b1;

	ptw4_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_kind   (in_data.kind),
		.in_ready  (in_ready),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.sts       (sts),
		.cmd       (cmd)
	);

	ptw4_dp #(
		.TABLE_FRAMES (TABLE_FRAMES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (out_data)
	);

`ifndef SYNTHESIS
	// One word at a time: no acceptance in the cycle after an acceptance
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while previous word in progress");

	// Only mapped answers carry an address or a size
	a_zero_unless_mapped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status != ST_MAPPED) |->
		(out_data.phys_addr == 52'd0) && (out_data.pg_size == SZ_4K))
		else $error("address or size on an unmapped answer");

	// Page size code stays in its range
	a_size_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.pg_size != 2'd3))
		else $error("illegal page size code");

	// A new answer appears only after a busy cycle
	a_answer_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("answer loaded while controller idle");
`endif

endmodule

`default_nettype wire

@@ tb/tb_page_table_walker_4level.sv @@
// Testbench for the four-level page table walker: table writes, walks, checked answers.
`default_nettype none

module tb_page_table_walker_4level;
	import ptw4_pkg::*;

	localparam int TABLE_FRAMES = 16;
	localparam int TABLE_WORDS  = TABLE_FRAMES * 512;
	localparam int PHASES       = 5;
	localparam int RANDOM_ITEMS = 190;

	// Track table contents and root frame, predict one answer per word
	class walk_scoreboard;
		bit [63:0] tbl [TABLE_WORDS];
		bit [3:0]  root;
		out_item_t expected_q[$];
		int        errors;

		function void set_root(bit [3:0] v);
			root = v;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function out_item_t translate(logic [47:0] va);
			out_item_t  r;
			logic [39:0] fr;
			logic [63:0] e;
			logic [8:0]  idx;
			r = '0;
			fr = 40'(root);
			if (fr >= TABLE_FRAMES) begin
				r.status = ST_OUTSIDE;
				return r;
			end
			for (int lvl = 0; lvl < 4; lvl++) begin
				idx = 9'(va >> (39 - 9 * lvl));
				e = tbl[{fr[3:0], idx}];
				if (!e[0]) begin
					r.status = ST_ABSENT;
					return r;
				end
				if (lvl == 3) begin
					r.status    = ST_MAPPED;
					r.phys_addr = {e[51:12], va[11:0]};
					r.pg_size   = SZ_4K;
					return r;
				end
				// huge bit: 1 GiB at the second level, 2 MiB at the first and third
				if (e[7]) begin
					r.status = ST_MAPPED;
					if (lvl == 1) begin
						r.phys_addr = {e[51:30], va[29:0]};
						r.pg_size   = SZ_1G;
					end else begin
						r.phys_addr = {e[51:21], va[20:0]};
						r.pg_size   = SZ_2M;
					end
					return r;
				end
				fr = e[51:12];
				if (fr >= TABLE_FRAMES) begin
					r.status = ST_OUTSIDE;
					return r;
				end
			end
			r.status = ST_ABSENT;
			return r;
		endfunction

		function out_item_t predict(in_item_t w);
			out_item_t r;
			r = '0;
			if (w.kind == KIND_WRITE) begin
				if (int'(w.word_index) < TABLE_WORDS)
					tbl[w.word_index] = w.entry_word;
				r.status = ST_WRITTEN;
			end else begin
				r = translate(w.virt_addr);
			end
			return r;
		endfunction

		function void note_word(in_item_t w);
			expected_q.push_back(predict(w));
		endfunction

		task report(string msg);
			if (errors < 100)
				$display("MISMATCH at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(out_item_t got);
			out_item_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("answer with none outstanding: status %0d", got.status));
				return;
			end
			want = expected_q.pop_front();
			if (got.status !== want.status)
				report($sformatf("status %0d, want %0d", got.status, want.status));
			if (got.phys_addr !== want.phys_addr)
				report($sformatf("phys_addr %h, want %h", got.phys_addr, want.phys_addr));
			if (got.pg_size !== want.pg_size)
				report($sformatf("pg_size %0d, want %0d", got.pg_size, want.pg_size));
		endtask
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [3:0] cfg_data = '0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	in_item_t   in_data = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	out_item_t  out_data;

	walk_scoreboard sb = new();
	bit             calm = 1'b0;
	bit [3:0]       cur_root = '0;
	int             phase_items;

	page_table_walker_4level #(
		.TABLE_FRAMES(TABLE_FRAMES)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Stall the answer side at random unless in a calm stretch
	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(0, 99) >= 9);
	end

	// Observe both handshakes at each edge
	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_result(out_data);
		if (in_valid && in_ready)
			sb.note_word(in_data);
	end

	// Hold one word on the input until it is taken
	task automatic send_word(in_item_t w);
		if (!calm && $urandom_range(0, 99) < 9) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		do @(posedge clk); while (!(in_valid && in_ready));
		phase_items++;
	endtask

	function automatic in_item_t noise_word();
		in_item_t w;
		w.kind       = 1'($urandom);
		w.word_index = 13'($urandom);
		w.entry_word = {$urandom, $urandom};
		w.virt_addr  = {16'($urandom), 32'($urandom)};
		return w;
	endfunction

	task automatic put(logic [12:0] idx, logic [63:0] e);
		in_item_t w;
		w = noise_word();
		w.kind       = KIND_WRITE;
		w.word_index = idx;
		w.entry_word = e;
		send_word(w);
	endtask

	task automatic look(logic [47:0] va);
		in_item_t w;
		w = noise_word();
		w.kind      = KIND_TRANSLATE;
		w.virt_addr = va;
		send_word(w);
	endtask

	function automatic logic [63:0] pte(logic [39:0] frame, bit huge);
		return {12'h000, frame, 4'h0, huge, 6'h00, 1'b1};
	endfunction

	// Lay out one path of table entries with random content, then walk it
	task automatic build_walk();
		logic [47:0] va;
		logic [47:0] va2;
		logic [63:0] e;
		logic [3:0]  f;
		logic [8:0]  idx;
		int          pick;
		bit          stop;
		va   = {16'($urandom), 32'($urandom)};
		f    = cur_root;
		stop = 1'b0;
		for (int lvl = 0; lvl < 4 && !stop; lvl++) begin
			e    = {$urandom, $urandom};
			pick = $urandom_range(0, 99);
			idx  = 9'(va >> (39 - 9 * lvl));
			if (pick < 6) begin
				e[0] = 1'b0;
				stop = 1'b1;
			end else begin
				e[0] = 1'b1;
				if (lvl == 3) begin
					stop = 1'b1;
				end else if (pick < 18) begin
					e[7] = 1'b1;
					stop = 1'b1;
				end else if (pick < 24) begin
					// point the next level past the store
					e[7] = 1'b0;
					e[16 + $urandom_range(0, 35)] = 1'b1;
					stop = 1'b1;
				end else begin
					e[7]     = 1'b0;
					e[51:12] = 40'($urandom_range(0, TABLE_FRAMES - 1));
				end
			end
			put({f, idx}, e);
			f = e[15:12];
		end
		look(va);
		if ($urandom_range(0, 1)) begin
			va2 = va;
			va2[20:0] = 21'($urandom);
			look(va2);
		end
	endtask

	task automatic write_root(bit [3:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		sb.set_root(v);
		cur_root = v;
	endtask

	task automatic drain();
		do @(posedge clk); while (sb.pending() != 0);
		repeat (8) @(posedge clk);
	endtask

	// Walk through each level, every special case of the answer
	task automatic directed_walks();
		logic [47:0] va_a;
		va_a = {9'd1, 9'd2, 9'd3, 9'd4, 12'hABC};
		look(va_a);
		put(13'(0 * 512 + 1), pte(40'd1, 1'b0));
		look(va_a);
		put(13'(1 * 512 + 2), pte(40'd2, 1'b0));
		look(va_a);
		put(13'(2 * 512 + 3), pte(40'd3, 1'b0));
		look(va_a);
		// last level: huge bit ignored, top bits and flags dropped
		put(13'(3 * 512 + 4), 64'hFFFF_FFFF_FFFF_FFFF);
		look(va_a);
		look({va_a[47:12], 12'hFFF});
		look({va_a[47:12], 12'h000});
		put(13'(3 * 512 + 4), pte(40'h00000_0000, 1'b0));
		look(va_a);
		put(13'(2 * 512 + 3), {12'hFFF, 40'hFF_FFFF_FFFF, 12'h081});
		look({va_a[47:21], 21'h1F_FFFF});
		put(13'(1 * 512 + 2), {12'h000, 40'hFF_FFFF_FFFF, 12'h081});
		look({va_a[47:30], 30'h3FFF_FFFF});
		put(13'(0 * 512 + 1), pte(40'hAB_CDEF_0123, 1'b1));
		look(va_a);
		put(13'(0 * 512 + 1), pte(40'd16, 1'b0));
		look(va_a);
		put(13'(0 * 512 + 1), pte(40'hFF_FFFF_FFFF, 1'b0));
		look(va_a);
		put(13'h1FFF, 64'hFFFF_FFFF_FFFF_FFFF);
		put(13'h0000, 64'h0);
		look(48'hFFFF_FFFF_FFFF);
	endtask

	initial begin
		bit [3:0] roots [PHASES];
		roots[0] = 4'd0;
		roots[1] = 4'd15;
		roots[2] = 4'($urandom);
		roots[3] = 4'($urandom);
		roots[4] = 4'($urandom_range(1, 14));
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < PHASES; p++) begin
			write_root(roots[p]);
			calm = (p == 2);
			phase_items = 0;
			if (p == 0)
				directed_walks();
			phase_items = 0;
			while (phase_items < RANDOM_ITEMS) begin
				if ($urandom_range(0, 99) < 70)
					build_walk();
				else
					send_word(noise_word());
			end
			in_valid <= 1'b0;
			drain();
		end
		calm = 1'b0;
		if (sb.pending() != 0)
			sb.report($sformatf("%0d answers never arrived", sb.pending()));
		if (sb.errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// Abort a hung run
	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire
